@@ src/bmif_pkg.sv @@
// Package for the box mean image filter.
// Holds payload types, field widths and configuration register indexes.
// No dependencies.
`default_nettype none

package bmif_pkg;

    localparam int PIXEL_W    = 24;
    localparam int ROW_W      = 13;
    localparam int HEIGHT_CAP = 4096;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int WS_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    typedef logic signed [PIXEL_W-1:0] pixel_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

endpackage

`default_nettype wire

@@ src/bmif_in_if.sv @@
// Input channel of the box mean image filter: valid, ready, pixel and drain.
// Depends on bmif_pkg.
`default_nettype none

interface bmif_in_if;
    import bmif_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;
    logic   drain;

    modport source (output valid, output pixel, output drain, input ready);
    modport sink (input valid, input pixel, input drain, output ready);
endinterface

`default_nettype wire

@@ src/bmif_out_if.sv @@
// Output channel of the box mean image filter: valid, ready, mean and frame end.
// Depends on bmif_pkg.
`default_nettype none

interface bmif_out_if;
    import bmif_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t mean_value;
    logic   frame_last;

    modport source (output valid, output mean_value, output frame_last, input ready);
    modport sink (input valid, input mean_value, input frame_last, output ready);
endinterface

`default_nettype wire

@@ src/box_mean_image_filter_top.sv @@
// Top level of the box mean image filter: ring memory, window walk and divider.
// Depends on bmif_pkg, bmif_in_if and bmif_out_if.
`default_nettype none

// Box mean filter over a raster frame. Each item is accepted only when the block is idle.
// An item that releases no result passes S_CHECK back to S_IDLE. A result whose window
// lies outside the frame goes from S_CHECK to S_FIN. Any other result passes S_BASE, the
// serial row-offset multiply over the ROW_W = 13 row bits, S_RUN, which walks the
// n <= k*k in-frame samples of the window, S_WAIT, S_PREP, S_DIV, the serial divider of
// SW = 24 + 2*log2(MAX_WINDOW) bits, and S_FIN. The last result of a frame passes S_BASE
// again to advance the frame base. The window walk reads one sample per cycle from the
// single ring memory of MAX_WIDTH*MAX_WINDOW entries. A finished result waits in the
// output register while the next item is taken; the next result stalls until that
// register is free. Drain items release the results still pending at the end of a frame.
module box_mean_image_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire bmif_pkg::cfg_idx_t  cfg_index,
    input  wire bmif_pkg::cfg_data_t cfg_data,
    bmif_in_if.sink             pix_in,
    bmif_out_if.source          res_out
);
    import bmif_pkg::*;

    localparam int RING = MAX_WIDTH * MAX_WINDOW;
    localparam int AW   = $clog2(RING);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int KW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = PIXEL_W + 2 * $clog2(MAX_WINDOW);
    localparam int CNTW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int DCW  = $clog2(SW + 1);
    localparam int MCW  = $clog2(ROW_W + 1);
    localparam int PW   = ROW_W + CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_BASE  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_PREP  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW:0] b);
        logic [AW+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s >= (AW+2)'(RING))
            s = s - (AW+2)'(RING);
        return s[AW-1:0];
    endfunction

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [WS_W-1:0] ws_reg;

    logic [PIXEL_W-1:0] mem [RING];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               rd_pend_reg;

    logic [2:0]      state_reg;
    logic [CW-1:0]   in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [CW-1:0]   out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic            in_ahead_reg;
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   out_base_reg;

    logic [CW-1:0]    u0_reg, u1_reg, u_reg;
    logic [ROW_W-1:0] v1_reg, v_reg;
    logic [AW-1:0]    mul_acc_reg;
    logic [ROW_W-1:0] mul_bits_reg;
    logic [MCW-1:0]   mul_cnt_reg;
    logic             frame_end_reg;
    logic [AW-1:0]    addr_reg, row_start_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic signed [SW-1:0] sum_reg;
    logic [SW-1:0]    quo_reg;
    logic [CNTW-1:0]  rem_reg;
    logic             neg_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic             last_reg;

    logic             out_valid_reg;
    pixel_t           out_mean_reg;
    logic             out_last_reg;

    logic [CW-1:0]    w_c;
    logic [ROW_W-1:0] h_c;
    logic [KW-1:0]    k_c, back, ahead;
    logic [CW:0]      lc_full;
    logic [ROW_W:0]   lr_full;
    logic [CW-1:0]    lc, u0;
    logic [ROW_W-1:0] lr, v0;
    logic [KW-1:0]    du_n, dv_n;
    logic [PW-1:0]    in_pos, lr_pos;
    logic             avail, empty;
    logic             in_fire, out_free;
    logic [CNTW:0]    trial;
    logic [AW-1:0]    mul_dbl, mul_step, row_addr;

    assign w_c = (fw_reg == '0) ? CW'(1) :
                 (32'(fw_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(fw_reg);
    assign h_c = (fh_reg == '0) ? ROW_W'(1) :
                 (32'(fh_reg) > HEIGHT_CAP) ? ROW_W'(HEIGHT_CAP) : ROW_W'(fh_reg);
    assign k_c = (ws_reg == '0) ? KW'(1) :
                 (32'(ws_reg) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(ws_reg);
    assign back  = k_c >> 1;
    assign ahead = k_c - KW'(1) - back;

    assign lc_full = {1'b0, out_col_reg} + (CW+1)'(ahead);
    assign lr_full = {1'b0, out_row_reg} + (ROW_W+1)'(ahead);
    assign lc = (lc_full > {1'b0, w_c - CW'(1)}) ? w_c - CW'(1) : lc_full[CW-1:0];
    assign lr = (lr_full > {1'b0, h_c - ROW_W'(1)}) ? h_c - ROW_W'(1) : lr_full[ROW_W-1:0];
    assign u0 = (out_col_reg > CW'(back)) ? out_col_reg - CW'(back) : '0;
    assign v0 = (out_row_reg > ROW_W'(back)) ? out_row_reg - ROW_W'(back) : '0;
    assign in_pos = PW'(in_row_reg) * PW'(w_c) + PW'(in_col_reg);
    assign lr_pos = PW'(lr) * PW'(w_c) + PW'(lc);
    assign avail = in_ahead_reg || (in_pos > lr_pos);
    assign empty = (u0 > lc) || (v0 > lr);
    assign du_n  = KW'(lc - u0) + KW'(1);
    assign dv_n  = KW'(lr - v0) + KW'(1);

    assign mul_dbl  = add_wrap(mul_acc_reg, {1'b0, mul_acc_reg});
    assign mul_step = add_wrap(mul_dbl, mul_bits_reg[ROW_W-1] ? (AW+1)'(w_c) : (AW+1)'(0));
    assign row_addr = add_wrap(add_wrap(out_base_reg, {1'b0, mul_acc_reg}), (AW+1)'(u0_reg));

    assign in_fire  = pix_in.valid && pix_in.ready;
    assign out_free = !out_valid_reg || res_out.ready;
    assign trial    = {rem_reg, quo_reg[SW-1]};

    assign pix_in.ready       = (state_reg == S_IDLE);
    assign res_out.valid      = out_valid_reg;
    assign res_out.mean_value = out_mean_reg;
    assign res_out.frame_last = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && !pix_in.drain)
            mem[wr_ptr_reg] <= pix_in.pixel;
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FW_W'(1024);
            fh_reg <= FH_W'(1024);
            ws_reg <= WS_W'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                CFG_WINDOW_SIZE:  ws_reg <= cfg_data[WS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            in_ahead_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            out_base_reg  <= '0;
            frame_end_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_RUN);
            if (rd_pend_reg)
                sum_reg <= sum_reg + {{(SW-PIXEL_W){rd_data_reg[PIXEL_W-1]}}, rd_data_reg};
            if (out_valid_reg && res_out.ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (!pix_in.drain)
                        begin
                            wr_ptr_reg <= add_wrap(wr_ptr_reg, (AW+1)'(1));
                            if (in_col_reg + CW'(1) >= w_c)
                            begin
                                in_col_reg <= '0;
                                if (in_row_reg + ROW_W'(1) >= h_c)
                                begin
                                    in_row_reg   <= '0;
                                    in_ahead_reg <= 1'b1;
                                end
                                else
                                    in_row_reg <= in_row_reg + ROW_W'(1);
                            end
                            else
                                in_col_reg <= in_col_reg + CW'(1);
                        end
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!avail)
                        state_reg <= S_IDLE;
                    else if (empty)
                    begin
                        quo_reg   <= '0;
                        neg_reg   <= 1'b0;
                        last_reg  <= 1'b0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        u0_reg        <= u0;
                        u1_reg        <= lc;
                        v1_reg        <= lr;
                        u_reg         <= u0;
                        v_reg         <= v0;
                        mul_acc_reg   <= '0;
                        mul_bits_reg  <= v0;
                        mul_cnt_reg   <= MCW'(ROW_W);
                        frame_end_reg <= 1'b0;
                        cnt_reg       <= CNTW'(du_n) * CNTW'(dv_n);
                        last_reg      <= (out_col_reg == w_c - CW'(1)) &&
                                         (out_row_reg == h_c - ROW_W'(1));
                        sum_reg       <= '0;
                        state_reg     <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    if (mul_cnt_reg != '0)
                    begin
                        mul_acc_reg  <= mul_step;
                        mul_bits_reg <= mul_bits_reg << 1;
                        mul_cnt_reg  <= mul_cnt_reg - MCW'(1);
                    end
                    else if (frame_end_reg)
                    begin
                        out_base_reg <= add_wrap(out_base_reg, {1'b0, mul_acc_reg});
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        addr_reg      <= row_addr;
                        row_start_reg <= row_addr;
                        state_reg     <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (u_reg == u1_reg)
                    begin
                        if (v_reg == v1_reg)
                            state_reg <= S_WAIT;
                        else
                        begin
                            v_reg         <= v_reg + ROW_W'(1);
                            u_reg         <= u0_reg;
                            row_start_reg <= add_wrap(row_start_reg, (AW+1)'(w_c));
                            addr_reg      <= add_wrap(row_start_reg, (AW+1)'(w_c));
                        end
                    end
                    else
                    begin
                        u_reg    <= u_reg + CW'(1);
                        addr_reg <= add_wrap(addr_reg, (AW+1)'(1));
                    end
                end
                S_WAIT:
                    state_reg <= S_PREP;
                S_PREP:
                begin
                    neg_reg     <= sum_reg[SW-1];
                    quo_reg     <= sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
                    rem_reg     <= '0;
                    div_cnt_reg <= DCW'(SW);
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (trial >= {1'b0, cnt_reg})
                    begin
                        rem_reg <= CNTW'(trial - {1'b0, cnt_reg});
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[CNTW-1:0];
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                    if (div_cnt_reg == DCW'(1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mean_reg  <= neg_reg ? pixel_t'(-quo_reg) : pixel_t'(quo_reg);
                        out_last_reg  <= last_reg;
                        if (out_col_reg + CW'(1) >= w_c)
                        begin
                            out_col_reg <= '0;
                            if (out_row_reg + ROW_W'(1) >= h_c)
                            begin
                                out_row_reg   <= '0;
                                in_ahead_reg  <= 1'b0;
                                frame_end_reg <= 1'b1;
                                mul_acc_reg   <= '0;
                                mul_bits_reg  <= h_c;
                                mul_cnt_reg   <= MCW'(ROW_W);
                                state_reg     <= S_BASE;
                            end
                            else
                            begin
                                out_row_reg <= out_row_reg + ROW_W'(1);
                                state_reg   <= S_IDLE;
                            end
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CW'(1);
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_CHECK)
        else $error("accepted item not followed by availability check");

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> (u_reg <= u1_reg && v_reg <= v1_reg))
        else $error("window walk left its bounds");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> out_valid_reg)
        else $error("finished result not presented");

    a_no_drain_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pix_in.drain) |=> $stable(wr_ptr_reg))
        else $error("drain item moved the write pointer");

endmodule

`default_nettype wire

@@ dv/box_mean_image_filter_top_tb.sv @@
// Self-checking testbench for box_mean_image_filter_top: drives frames of raster pixels
// and drain items, predicts each window mean in a local model and checks every result.
// Depends on bmif_pkg, bmif_in_if, bmif_out_if and the filter top level.
`timescale 1ns / 1ps

module box_mean_image_filter_top_tb;
    import bmif_pkg::*;

    localparam int RING = 1024 * 8;

    typedef struct {
        pixel_t pixel;
        logic   drain;
    } pix_item_t;

    typedef struct {
        pixel_t mean_value;
        logic   frame_last;
    } mean_item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    cfg_data_t cfg_data;

    bmif_in_if pix();
    bmif_out_if res();

    box_mean_image_filter_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pix_in(pix),
        .res_out(res)
    );

    pix_item_t pending_pixels[$];
    mean_item_t expected_means[$];
    int mismatches;
    int accepted_items;
    int cycle_count;
    int hold_cycles;
    bit in_took;
    bit hold_done;

    int unsigned m_width, m_height, m_win;
    int ring[RING];
    int unsigned in_col, in_row, out_col, out_row, wr_ptr, out_base;
    bit in_ahead;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit window_mean(input pix_item_t it, output mean_item_t r);
        int unsigned w, h, k, back, fwd, lc, lr, avail, u0, v0, u, v;
        longint sum, cnt;
        w = clamp(m_width, 1024);
        h = clamp(m_height, HEIGHT_CAP);
        k = clamp(m_win, 8);
        back = k / 2;
        fwd = k - 1 - back;
        sum = 0;
        if (!it.drain)
        begin
            ring[wr_ptr] = it.pixel;
            wr_ptr = (wr_ptr + 1) % RING;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    in_ahead = 1;
                end
            end
        end
        lc = (out_col + fwd > w - 1) ? w - 1 : out_col + fwd;
        lr = (out_row + fwd > h - 1) ? h - 1 : out_row + fwd;
        avail = in_ahead ? w * h : in_row * w + in_col;
        if (avail <= lr * w + lc) return 0;
        u0 = out_col > back ? out_col - back : 0;
        v0 = out_row > back ? out_row - back : 0;
        if (u0 <= lc && v0 <= lr)
        begin
            for (v = v0; v <= lr; v++)
                for (u = u0; u <= lc; u++)
                    sum += ring[(out_base + v * w + u) % RING];
            cnt = longint'(lc - u0 + 1) * longint'(lr - v0 + 1);
            r.mean_value = pixel_t'(sum / cnt);
            r.frame_last = (out_col == w - 1 && out_row == h - 1);
        end
        else
        begin
            r.mean_value = '0;
            r.frame_last = 1'b0;
        end
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= h)
            begin
                out_row = 0;
                out_base = (out_base + w * h) % RING;
                in_ahead = 0;
            end
        end
        return 1;
    endfunction

    function automatic pixel_t rand_pixel();
        case ($urandom_range(0, 5))
            0: return pixel_t'(24'h7FFFFF);
            1: return pixel_t'(24'h800000);
            2: return pixel_t'($urandom_range(0, 8191)) - pixel_t'(4096);
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic send(input pix_item_t it);
        mean_item_t r;
        if (window_mean(it, r))
            expected_means.insert(expected_means.size(), r);
        pending_pixels.insert(pending_pixels.size(), it);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= cfg_data_t'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned k,
                             input int noise, inout int n_items);
        pix_item_t it;
        int unsigned n;
        wait (pending_pixels.size() == 0 && expected_means.size() == 0 && !pix.valid);
        repeat (200) @(negedge clk);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_WINDOW_SIZE, k);
        m_width = w & 12'h7FF;
        m_height = h & 14'h1FFF;
        m_win = k & 4'hF;
        n = clamp(m_width, 1024) * clamp(m_height, HEIGHT_CAP);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise)
            begin
                it.pixel = pixel_t'($urandom);
                it.drain = 1'b1;
                send(it);
            end
            it.pixel = rand_pixel();
            it.drain = 1'b0;
            send(it);
            n_items++;
        end
        while (in_ahead)
        begin
            it.pixel = pixel_t'($urandom);
            it.drain = 1'b1;
            send(it);
            n_items++;
        end
    endtask

    always @(posedge clk)
    begin
        in_took <= pix.valid && pix.ready;
        cycle_count <= cycle_count + 1;
        if (pix.valid && pix.ready)
            accepted_items <= accepted_items + 1;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!pix.valid || in_took))
        begin
            if (pending_pixels.size() > 0 &&
                ((cycle_count > 3000 && cycle_count < 12000) || $urandom_range(0, 99) >= 7))
            begin
                pix.valid <= 1'b1;
                pix.pixel <= pending_pixels[0].pixel;
                pix.drain <= pending_pixels[0].drain;
                pending_pixels.pop_front();
            end
            else
                pix.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!hold_done && accepted_items >= 300)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 400)
                hold_done <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        res.ready <= (hold_done || accepted_items < 300) &&
                     ((cycle_count > 3000 && cycle_count < 12000) || $urandom_range(0, 99) >= 7);
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result mean=%0d last=%0b",
                             res.mean_value, res.frame_last);
            end
            else
            begin
                if (res.mean_value !== expected_means[0].mean_value ||
                    res.frame_last !== expected_means[0].frame_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected mean=%0d last=%0b, got mean=%0d last=%0b",
                                 expected_means[0].mean_value, expected_means[0].frame_last,
                                 res.mean_value, res.frame_last);
                end
                expected_means.pop_front();
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int n_items;
        pix_item_t it;
        n_items = 0;
        mismatches = 0;
        accepted_items = 0;
        cycle_count = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        in_took = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        pix.drain = 1'b0;
        res.ready = 1'b0;
        m_width = 1024;
        m_height = 1024;
        m_win = 5;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        wr_ptr = 0; out_base = 0; in_ahead = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain with nothing pending
        it.pixel = pixel_t'(24'h7FFFFF);
        it.drain = 1'b1;
        send(it);
        run_frame(3, 2, 1, 0, n_items);
        run_frame(0, 0, 0, 0, n_items);
        run_frame(4, 3, 8, 10, n_items);
        run_frame(3, 3, 2, 0, n_items);
        run_frame(2047, 1, 15, 0, n_items);

        while (n_items < 1150)
        begin
            if ($urandom_range(0, 9) == 0)
                run_frame($urandom_range(1, 40), $urandom_range(1, 4),
                          $urandom_range(0, 15), 5, n_items);
            else
                run_frame($urandom_range(1, 12), $urandom_range(1, 10),
                          $urandom_range(0, 9), 5, n_items);
        end

        wait (pending_pixels.size() == 0 && expected_means.size() == 0 && !pix.valid);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_means.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ box_mean_image_filter_top.f @@
src/bmif_pkg.sv
src/bmif_in_if.sv
src/bmif_out_if.sv
src/box_mean_image_filter_top.sv
dv/box_mean_image_filter_top_tb.sv
